/* rtl/core/scmd_pkg.sv */
// Shared types and constants for the servo command encoder.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package scmd_pkg;

  // Command function codes carried on the func field.
  localparam logic [2:0] F_LOAD = 3'd0;
  localparam logic [2:0] F_RAW  = 3'd1;
  localparam logic [2:0] F_NORM = 3'd2;
  localparam logic [2:0] F_SPD  = 3'd3;
  localparam logic [2:0] F_ACC  = 3'd4;
  localparam logic [2:0] F_POS  = 3'd5;
  localparam logic [2:0] F_ERR  = 3'd6;
  localparam logic [2:0] F_HOME = 3'd7;

  // Compact-protocol command bytes.
  localparam logic [7:0] CMD_TARGET = 8'h84;
  localparam logic [7:0] CMD_SPEED  = 8'h87;
  localparam logic [7:0] CMD_ACCEL  = 8'h89;
  localparam logic [7:0] CMD_POS    = 8'h90;
  localparam logic [7:0] CMD_ERRORS = 8'hA1;
  localparam logic [7:0] CMD_HOME   = 8'hA2;

  // Last index within a command of one, two or four bytes.
  localparam logic [1:0] LAST_OF_1 = 2'd0;
  localparam logic [1:0] LAST_OF_2 = 2'd1;
  localparam logic [1:0] LAST_OF_4 = 2'd3;

  typedef struct packed {
    logic [13:0] min_us;
    logic [13:0] max_us;
    logic [13:0] neutral_pulse;
  } limits_t;

  localparam limits_t LIMITS_DEFAULT = '{
    min_us:        14'd1000,
    max_us:        14'd2000,
    neutral_pulse: 14'd1500
  };

  // One command handed to the byte serializer.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } cmd_t;

  // Item fields that travel down the pipeline beside the arithmetic.
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  channel;
    logic [15:0] raw;
    logic        ch_ok;
  } item_t;

endpackage

`default_nettype wire

/* rtl/core/scmd_limits_mem.sv */
// Per-channel limit table: one synchronous memory with a registered read port.
// Uses scmd_pkg (limits_t, LIMITS_DEFAULT).
`default_nettype none

module scmd_limits_mem import scmd_pkg::*; #(
  parameter int NUM_CHANNELS = 24,
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] addr,
  input  wire limits_t       wr_data,
  output limits_t            rd_data
);

  limits_t                 mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld;
  limits_t                 rd_q;
  logic                    rd_hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // An entry never written reads as the default limits.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_q   <= mem[addr];
      rd_hit <= vld[addr];
    end
  end

  assign rd_data = rd_hit ? rd_q : LIMITS_DEFAULT;

endmodule

`default_nettype wire

/* rtl/core/scmd_norm_map.sv */
// Three-stage piecewise-linear map of a Q1.15 position onto the channel range.
// Uses scmd_pkg (limits_t).
`default_nettype none

module scmd_norm_map import scmd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire limits_t            lim,
  input  wire logic signed [15:0] norm,
  output logic [15:0]             q_norm
);

  logic [14:0]        mid_sum;
  logic [13:0]        c1;
  logic signed [14:0] d1;

  logic [13:0]        c2, mn2, mx2;
  logic signed [14:0] d2;
  logic signed [15:0] n2;

  logic [13:0]        c3, mn3, mx3;
  logic signed [30:0] prod3;

  logic signed [31:0] s_raw, s_lo, s_hi, s_a, s_b;

  // Center and slope for the side of neutral that the target falls on.
  always_comb begin
    mid_sum = {1'b0, lim.min_us} + {1'b0, lim.max_us};
    c1 = (lim.neutral_pulse != 14'd0) ? lim.neutral_pulse : mid_sum[14:1];
    if (norm <= 16'sd0) begin
      d1 = $signed({1'b0, c1}) - $signed({1'b0, lim.min_us});
    end else begin
      d1 = $signed({1'b0, lim.max_us}) - $signed({1'b0, c1});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2  <= c1;
      d2  <= d1;
      n2  <= norm;
      mn2 <= lim.min_us;
      mx2 <= lim.max_us;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= n2 * d2;
      c3    <= c2;
      mn3   <= mn2;
      mx3   <= mx2;
    end
  end

  // Pulse times 32768, clamped up to min then down to max; both bounds are
  // nonnegative, so the result never goes below zero.
  always_comb begin
    s_raw = $signed({3'b000, c3, 15'd0}) + 32'(prod3);
    s_lo  = $signed({3'b000, mn3, 15'd0});
    s_hi  = $signed({3'b000, mx3, 15'd0});
    s_a   = (s_raw < s_lo) ? s_lo : s_raw;
    s_b   = (s_a > s_hi) ? s_hi : s_a;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_norm <= s_b[28:13];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scmd_byte_ser.sv */
// Output serializer: holds one command and sends it a byte per transaction.
// Uses scmd_pkg (cmd_t).
`default_nettype none

module scmd_byte_ser import scmd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load_valid,
  input  wire cmd_t load_cmd,
  output logic      can_load,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] tx_byte,
  output logic      last_byte
);

  logic       busy;
  cmd_t       cmd;
  logic [1:0] idx;

  assign tx_byte   = cmd.bytes[idx];
  assign last_byte = (idx == cmd.last_idx);
  assign out_valid = busy;
  // Take a new command when empty or as the final byte leaves.
  assign can_load  = !busy || (out_ready && last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (can_load) begin
      busy <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      cmd <= load_cmd;
      idx <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/servo_command_encoder_core.sv */
// Top level of the servo command encoder: input pipeline, limit table,
// normalized mapping, target clamp and byte serializer.
// Uses scmd_pkg, scmd_limits_mem, scmd_norm_map and scmd_byte_ser.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_ready  | func, channel, raw_value, norm_value,
//          |                      | min_us, max_us, neutral_pulse
//  output  | out_valid / out_ready| tx_byte, last_byte
//
// Flow: an accepted command passes stages s1 to s4 and is loaded into the
// serializer register, which offers its bytes. Sustained intake is paced by
// the bytes each command emits (four for targets, speed and accel, two for a
// position query, one for error query and home); a load or a rejected channel
// emits none. New commands enter while older bytes go out; the stages ahead of
// the serializer share one enable, low only while a finished command waits.
// Reset clears pipeline valids, the serializer and the per-channel valid bits
// of the limit table at once; no clearing pass, the block is ready next cycle.
`default_nettype none

module servo_command_encoder_core import scmd_pkg::*; #(
  parameter int NUM_CHANNELS = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         func,
  input  wire logic [7:0]         channel,
  input  wire logic [15:0]        raw_value,
  input  wire logic signed [15:0] norm_value,
  input  wire logic [13:0]        min_us,
  input  wire logic [13:0]        max_us,
  input  wire logic [13:0]        neutral_pulse,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              tx_byte,
  output logic                    last_byte
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [8:0] NUM_CH_W = 9'(NUM_CHANNELS);

  logic               en;
  logic               take;
  logic               ch_ok0;
  logic               wr_en;
  limits_t            wr_lim;
  limits_t            rd_lim;

  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  item_t              item0, s1_item, s2_item, s3_item, s4_item;
  logic signed [15:0] s1_norm;
  limits_t            s2_lim, s3_lim, s4_lim;
  logic [15:0]        q_norm;

  logic [15:0]        lo0, hi0, lo, hi, q_sel, q_a, q_clamp;
  logic               s4_has;
  cmd_t               s4_cmd;
  logic               ser_can_load;

  // Stall the whole front end only while a command with bytes waits on the
  // serializer; items that emit nothing drop out of the last stage freely.
  assign en       = !(s4_valid && s4_has && !ser_can_load);
  assign in_ready = en;
  assign take     = in_valid && en;

  assign ch_ok0 = ({1'b0, channel} < NUM_CH_W);

  always_comb begin
    item0.func    = func;
    item0.channel = channel;
    item0.raw     = raw_value;
    item0.ch_ok   = ch_ok0;
  end

  // A load writes at acceptance, so any later command reads the new entry.
  assign wr_en = take && (func == F_LOAD) && ch_ok0;
  always_comb begin
    wr_lim.min_us        = min_us;
    wr_lim.max_us        = max_us;
    wr_lim.neutral_pulse = neutral_pulse;
  end

  scmd_limits_mem #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .wr_en   (wr_en),
    .addr    (channel[AW-1:0]),
    .wr_data (wr_lim),
    .rd_data (rd_lim)
  );

  scmd_norm_map u_norm (
    .clk    (clk),
    .en     (en),
    .lim    (rd_lim),
    .norm   (s1_norm),
    .q_norm (q_norm)
  );

  // Pipeline valids advance together on the shared enable.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // Carry the item fields and the read limits alongside the mapping stages.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item <= item0;
      s1_norm <= norm_value;
      s2_item <= s1_item;
      s2_lim  <= rd_lim;
      s3_item <= s2_item;
      s3_lim  <= s2_lim;
      s4_item <= s3_item;
      s4_lim  <= s3_lim;
    end
  end

  // Target clamp in quarter microseconds, bounds swapped if inverted.
  always_comb begin
    lo0     = {s4_lim.min_us, 2'b00};
    hi0     = {s4_lim.max_us, 2'b00};
    lo      = (lo0 > hi0) ? hi0 : lo0;
    hi      = (lo0 > hi0) ? lo0 : hi0;
    q_sel   = (s4_item.func == F_NORM) ? q_norm : s4_item.raw;
    q_a     = (q_sel < lo) ? lo : q_sel;
    q_clamp = (q_a > hi) ? hi : q_a;
  end

  // Build the byte sequence for the command in the last stage.
  always_comb begin
    s4_has          = s4_item.ch_ok;
    s4_cmd.bytes[0] = CMD_TARGET;
    s4_cmd.bytes[1] = s4_item.channel;
    s4_cmd.bytes[2] = {1'b0, q_clamp[6:0]};
    s4_cmd.bytes[3] = {1'b0, q_clamp[13:7]};
    s4_cmd.last_idx = LAST_OF_4;
    case (s4_item.func)
      F_LOAD: begin
        s4_has = 1'b0;
      end
      F_RAW, F_NORM: begin
      end
      F_SPD, F_ACC: begin
        s4_cmd.bytes[0] = (s4_item.func == F_SPD) ? CMD_SPEED : CMD_ACCEL;
        s4_cmd.bytes[2] = {1'b0, s4_item.raw[6:0]};
        s4_cmd.bytes[3] = {1'b0, s4_item.raw[13:7]};
      end
      F_POS: begin
        s4_cmd.bytes[0] = CMD_POS;
        s4_cmd.last_idx = LAST_OF_2;
      end
      F_ERR: begin
        s4_has          = 1'b1;
        s4_cmd.bytes[0] = CMD_ERRORS;
        s4_cmd.last_idx = LAST_OF_1;
      end
      default: begin
        s4_has          = 1'b1;
        s4_cmd.bytes[0] = CMD_HOME;
        s4_cmd.last_idx = LAST_OF_1;
      end
    endcase
  end

  scmd_byte_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s4_valid && s4_has),
    .load_cmd   (s4_cmd),
    .can_load   (ser_can_load),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .last_byte  (last_byte)
  );

  // A command never breaks off in the middle: after a non-final byte
  // transaction another byte is offered.
  a_cmd_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=> out_valid)
    else $error("command ended before its final byte");

  // A target handed to the serializer lies inside the channel range.
  a_target_in_range: assert property (@(posedge clk) disable iff (rst)
    s4_valid && s4_has && (s4_item.func == F_RAW || s4_item.func == F_NORM)
      |-> (q_clamp >= lo) && (q_clamp <= hi))
    else $error("target outside channel range");

  // Reset leaves no byte on the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

/* dv/servo_command_encoder_core_tb.sv */
// Self-checking testbench for servo_command_encoder_core: drives servo commands,
// predicts the compact-protocol byte stream and checks every output transaction.
// Depends on scmd_pkg and servo_command_encoder_core from rtl/core.
`timescale 1ns / 1ps

module servo_command_encoder_core_tb;
  import scmd_pkg::*;

  localparam int NUM_CH       = 24;
  localparam int RST_CYCLES   = 6;
  localparam int DRAIN_CYCLES = 24;    // extra wait after the last expected byte
  localparam int IDLE_LIMIT   = 3000;  // cycles with no transaction on either side
  localparam int RAND_CMDS    = 88;
  localparam int HOLD_AT      = 40;    // input transactions before the long hold-off
  localparam int HOLD_CYCLES  = 120;

  // One servo command as offered on the input channel.
  typedef struct {
    logic [2:0]         func;
    logic [7:0]         channel;
    logic [15:0]        raw;
    logic signed [15:0] norm;
    logic [13:0]        mn;
    logic [13:0]        mx;
    logic [13:0]        neu;
  } servo_cmd_t;

  // One byte on the controller link.
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } link_byte_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         func = F_LOAD;
  logic [7:0]         channel = '0;
  logic [15:0]        raw_value = '0;
  logic signed [15:0] norm_value = '0;
  logic [13:0]        min_us = '0;
  logic [13:0]        max_us = '0;
  logic [13:0]        neutral_pulse = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         tx_byte;
  logic               last_byte;

  servo_cmd_t pending_cmds[$];
  link_byte_t link_bytes_due[$];
  limits_t    chan_limits[NUM_CH];

  logic in_fire = 1'b0;
  int   n_cmds_in = 0;
  int   n_errors = 0;
  int   idle_cycles = 0;

  servo_command_encoder_core #(
    .NUM_CHANNELS(NUM_CH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .channel      (channel),
    .raw_value    (raw_value),
    .norm_value   (norm_value),
    .min_us       (min_us),
    .max_us       (max_us),
    .neutral_pulse(neutral_pulse),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tx_byte      (tx_byte),
    .last_byte    (last_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction: a private copy of the limit table and the byte encoding.
  // ---------------------------------------------------------------------------

  // Clamp a quarter-microsecond target to the channel range, bounds swapped
  // when the table holds them inverted.
  function automatic logic [15:0] clamp_pulse(limits_t l, logic [15:0] q);
    logic [15:0] lo, hi, t;
    lo = {l.min_us, 2'b00};
    hi = {l.max_us, 2'b00};
    if (lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  // Map a Q1.15 position through the neutral point; the result is the pulse
  // in us scaled by 32768, pre-clamped without a swap, then floored to
  // quarter microseconds.
  function automatic logic [15:0] map_norm_pulse(limits_t l, logic signed [15:0] n);
    longint nv, mn, mx, c, d, s;
    nv = n;
    mn = l.min_us;
    mx = l.max_us;
    c  = (l.neutral_pulse != 0) ? longint'(l.neutral_pulse) : (mn + mx) / 2;
    d  = (nv <= 0) ? (c - mn) : (mx - c);
    s  = c * 32768 + nv * d;
    if (s < mn * 32768) s = mn * 32768;
    if (s > mx * 32768) s = mx * 32768;
    if (s < 0) s = 0;
    s = s >>> 13;
    return s[15:0];
  endfunction

  task automatic push_link_byte(logic [7:0] b, logic last);
    link_bytes_due.push_back('{tx: b, last: last});
  endtask

  task automatic push_four(logic [7:0] cmd, logic [7:0] ch, logic [15:0] v);
    push_link_byte(cmd, 1'b0);
    push_link_byte(ch, 1'b0);
    push_link_byte({1'b0, v[6:0]}, 1'b0);
    push_link_byte({1'b0, v[13:7]}, 1'b1);
  endtask

  // Update the table and queue the bytes that one accepted command causes.
  task automatic encode_cmd(servo_cmd_t c);
    limits_t l;
    if (c.func == F_ERR) begin
      push_link_byte(CMD_ERRORS, 1'b1);
    end else if (c.func == F_HOME) begin
      push_link_byte(CMD_HOME, 1'b1);
    end else if (c.channel < NUM_CH) begin
      l = chan_limits[c.channel];
      case (c.func)
        F_LOAD: begin
          chan_limits[c.channel] = '{min_us: c.mn, max_us: c.mx, neutral_pulse: c.neu};
        end
        F_RAW:  push_four(CMD_TARGET, c.channel, clamp_pulse(l, c.raw));
        F_NORM: push_four(CMD_TARGET, c.channel, clamp_pulse(l, map_norm_pulse(l, c.norm)));
        F_SPD:  push_four(CMD_SPEED, c.channel, c.raw);
        F_ACC:  push_four(CMD_ACCEL, c.channel, c.raw);
        default: begin
          push_link_byte(CMD_POS, 1'b0);
          push_link_byte(c.channel, 1'b1);
        end
      endcase
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("%0t ns: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  function automatic servo_cmd_t mk_cmd(logic [2:0] f, logic [7:0] ch, logic [15:0] raw,
                                        logic signed [15:0] norm, logic [13:0] mn,
                                        logic [13:0] mx, logic [13:0] neu);
    return '{func: f, channel: ch, raw: raw, norm: norm, mn: mn, mx: mx, neu: neu};
  endfunction

  // Mostly sane commands on valid channels, with full-width noise in the
  // fields each command ignores and a share of wild limits and bad channels.
  function automatic servo_cmd_t rand_cmd();
    servo_cmd_t c;
    int r;
    c = mk_cmd(F_LOAD, 8'($urandom_range(0, NUM_CH - 1)), 16'($urandom),
               16'($urandom), 14'($urandom), 14'($urandom), 14'($urandom));
    r = $urandom_range(0, 99);
    if (r < 16)      c.func = F_LOAD;
    else if (r < 34) c.func = F_RAW;
    else if (r < 60) c.func = F_NORM;
    else if (r < 68) c.func = F_SPD;
    else if (r < 76) c.func = F_ACC;
    else if (r < 86) c.func = F_POS;
    else if (r < 93) c.func = F_ERR;
    else             c.func = F_HOME;
    if ($urandom_range(0, 9) == 0) c.channel = 8'($urandom_range(NUM_CH, 255));
    if (c.func == F_LOAD && $urandom_range(0, 4) < 3) begin
      c.mn  = 14'($urandom_range(400, 1500));
      c.mx  = 14'($urandom_range(1500, 2600));
      c.neu = ($urandom_range(0, 2) == 0) ? 14'd0 : 14'($urandom_range(c.mn, c.mx));
    end else if (c.func == F_LOAD && $urandom_range(0, 2) == 0) begin
      c.neu = 14'd0;
    end
    if (c.func == F_RAW && $urandom_range(0, 1) == 0)
      c.raw = 16'($urandom_range(1200, 11000));
    if (c.func == F_NORM && $urandom_range(0, 7) == 0)
      c.norm = ($urandom_range(0, 1) == 0) ? 16'sh8000 : 16'sh7FFF;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued commands at the falling edge in bursts with gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left = 0;

  always @(negedge clk) begin
    servo_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the payload until the transaction goes through
    end else if (gap_left != 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending_cmds.size() != 0) begin
      c = pending_cmds.pop_front();
      func          <= c.func;
      channel       <= c.channel;
      raw_value     <= c.raw;
      norm_value    <= c.norm;
      min_us        <= c.mn;
      max_us        <= c.mx;
      neutral_pulse <= c.neu;
      in_valid      <= 1'b1;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 16);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left--;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a pattern that changes mode now and then, and hold off
  // once for a long stretch so the pipeline backs up into the input.
  // ---------------------------------------------------------------------------
  int  rx_mode = 0;
  int  rx_mode_left = 16;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  logic [7:0] rx_mask = 8'b1011_0110;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_cmds_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= rx_mask[0];
      endcase
      rx_mask = {rx_mask[0], rx_mask[7:1]};
      if (rx_mode_left <= 1) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(8, 64);
      end else begin
        rx_mode_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check output transactions against the oldest expected byte, and
  // predict the bytes of each input transaction. Both sample at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    link_byte_t want;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      if (link_bytes_due.size() == 0) begin
        report_mismatch("unexpected tx_byte", tx_byte, 0);
      end else begin
        want = link_bytes_due.pop_front();
        if (tx_byte !== want.tx) report_mismatch("tx_byte", tx_byte, want.tx);
        if (last_byte !== want.last) report_mismatch("last_byte", last_byte, want.last);
      end
    end
    if (!rst && in_valid && in_ready) begin
      n_cmds_in++;
      encode_cmd(mk_cmd(func, channel, raw_value, norm_value, min_us, max_us,
                        neutral_pulse));
    end
  end

  // Watchdog: drop the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed commands, random commands, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NUM_CH; i++) chan_limits[i] = LIMITS_DEFAULT;

    // Default limits: raw extremes, normalized extremes and center.
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd0,   16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd0,   16'hFFFF, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd1,   16'h0000, 16'sh8000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd1,   16'h0000, 16'sh7FFF, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd1,   16'hFFFF, 16'sh0000, 14'd0, 14'd0, 14'd0));
    // Speed and accel with bits above bit 13 set; position on the top channel.
    pending_cmds.push_back(mk_cmd(F_SPD,  8'd2,   16'hFFFF, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_ACC,  8'd23,  16'hC001, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_POS,  8'd23,  16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    // Error query and home ignore the channel, even an out-of-range one.
    pending_cmds.push_back(mk_cmd(F_ERR,  8'd255, 16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_HOME, 8'd200, 16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    // Bad channel: load, target and position are all dropped.
    pending_cmds.push_back(mk_cmd(F_LOAD, 8'd24,  16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd24,  16'h1234, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_POS,  8'd255, 16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    // Inverted limits with midpoint neutral.
    pending_cmds.push_back(mk_cmd(F_LOAD, 8'd3,   16'h0000, 16'sh0000, 14'd3000, 14'd1000, 14'd0));
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd3,   16'h2000, 16'sh0000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd3,   16'h0000, 16'sh7FFF, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd3,   16'h0000, 16'sh8000, 14'd0, 14'd0, 14'd0));
    // Full-range limits.
    pending_cmds.push_back(mk_cmd(F_LOAD, 8'd4,   16'h0000, 16'sh0000, 14'd0, 14'd16383, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd4,   16'h0000, 16'sh7FFF, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd4,   16'h0000, 16'sh8000, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd4,   16'hFFFF, 16'sh0000, 14'd0, 14'd0, 14'd0));
    // Degenerate range at the top of the field.
    pending_cmds.push_back(mk_cmd(F_LOAD, 8'd5,   16'h0000, 16'sh0000, 14'd16383, 14'd16383,
                                  14'd16383));
    pending_cmds.push_back(mk_cmd(F_NORM, 8'd5,   16'h0000, -16'sd1, 14'd0, 14'd0, 14'd0));
    pending_cmds.push_back(mk_cmd(F_RAW,  8'd5,   16'h0000, 16'sh0000, 14'd0, 14'd0, 14'd0));

    for (int i = 0; i < RAND_CMDS; i++) pending_cmds.push_back(rand_cmd());

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last input transaction, then for the last expected byte.
    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (link_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (link_bytes_due.size() != 0)
      report_mismatch("bytes still outstanding", 0, link_bytes_due.size());
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
